>>> sv/itcla_pkg.sv
package itcla_pkg;

  typedef enum logic [1:0] {
    REQ_PIXEL = 2'd0,
    REQ_TONE  = 2'd1,
    REQ_GAIN  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam int unsigned CHROMA_W    = 16;
  localparam int unsigned GAIN_W      = 22;
  localparam int unsigned MAG_W       = 32;
  localparam int unsigned ROOT_W      = 16;
  localparam int unsigned SQRT_STEPS  = 16;
  localparam logic [7:0]  ADDR_ENABLE = 8'h00;

  // One restoring step of the integer square root, two radicand bits per step.
  typedef struct packed {
    logic        vld;
    logic [31:0] rem;
    logic [31:0] rad;
    logic [ROOT_W-1:0] root;
  } sq_stage_t;

endpackage

>>> sv/ipt_tone_and_chroma_lut_adjust_core.sv
// IPT tone and chroma adjust. Takes one request per clock: pixels, tone table writes
// and gain table writes share one ordered stream. A pixel passes a 16-step pipelined
// square root of P*P+T*T, a registered tone and gain memory read, then a registered gain
// multiply and a registered saturate. Writes and pixels pass the same pipeline, so a
// table write applies to every later pixel.
// The whole pipeline stalls only when the output register is full and not taken.
// Neither table is cleared after reset; write every entry a pixel may reach.
module ipt_tone_and_chroma_lut_adjust_core
  import itcla_pkg::*;
#(
  parameter int unsigned TONE_DEPTH     = 65536,
  parameter int unsigned GAIN_DEPTH     = 46341,
  parameter int unsigned GAIN_FRAC_BITS = 15
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_req_type,
  input  logic [15:0]                in_in_intensity,
  input  logic signed [15:0]         in_in_p,
  input  logic signed [15:0]         in_in_t,
  input  logic [15:0]                in_table_index,
  input  logic [21:0]                in_table_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [15:0]                out_out_intensity,
  output logic signed [15:0]         out_out_p,
  output logic signed [15:0]         out_out_t,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [1:0]                 cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  localparam int unsigned TA_W = $clog2(TONE_DEPTH);
  localparam int unsigned GA_W = $clog2(GAIN_DEPTH);
  localparam int unsigned DLY  = SQRT_STEPS + 1;
  localparam int unsigned PW   = CHROMA_W + GAIN_W + 1;
  localparam logic signed [PW-1:0] SAT_HI = PW'(32767);
  localparam logic signed [PW-1:0] SAT_LO = -PW'(32767);

  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] ii;
    logic [15:0] p;
    logic [15:0] t;
    logic [15:0] idx;
    logic [21:0] val;
  } item_t;

  logic en_r;
  logic adv;
  logic o_vld_r;

  // ---- configuration
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && {cfg_paddr, 6'b0} == {ADDR_ENABLE[1:0], 6'b0}) begin
      en_r <= cfg_pwdata[0];
    end
  end
  assign cfg_prdata = (cfg_paddr == ADDR_ENABLE[1:0]) ? {31'd0, en_r} : 32'd0;

  // ---- pipeline advance
  assign adv      = !o_vld_r || out_ready;
  assign in_ready = adv;

  // ---- square root of magnitude
  logic signed [31:0] pp, tt;
  logic [MAG_W-1:0] mag;
  assign pp  = 32'(in_in_p) * 32'(in_in_p);
  assign tt  = 32'(in_in_t) * 32'(in_in_t);
  assign mag = MAG_W'(pp) + MAG_W'(tt);

  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  itcla_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_vld(in_valid && in_ready),
    .in_mag(mag),
    .out_vld(sq_vld), .out_root(sq_root)
  );

  // item travels beside the root pipeline
  item_t dly_r [DLY];
  always_ff @(posedge clk) begin
    if (adv) begin
      dly_r[0] <= '{in_req_type, in_in_intensity, in_in_p, in_in_t,
                    in_table_index, in_table_value};
      for (int k = 1; k < DLY; k++) dly_r[k] <= dly_r[k-1];
    end
  end
  item_t cur;
  assign cur = dly_r[DLY-1];

  // ---- memories: write and read in the same stage keep request order
  logic [15:0]       tone_mem [TONE_DEPTH];
  logic [GAIN_W-1:0] gain_mem [GAIN_DEPTH];
  logic [TA_W-1:0] t_addr;
  logic [GA_W-1:0] g_addr;
  logic            do_pix;

  always_comb begin
    t_addr = (32'(cur.ii) >= TONE_DEPTH) ? TA_W'(TONE_DEPTH - 1) : TA_W'(cur.ii);
    g_addr = (32'(sq_root) >= GAIN_DEPTH) ? GA_W'(GAIN_DEPTH - 1) : GA_W'(sq_root);
    do_pix = sq_vld && (cur.req == REQ_PIXEL);
  end

  logic [15:0]       tone_rd_r;
  logic [GAIN_W-1:0] gain_rd_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      if (sq_vld && cur.req == REQ_TONE && 32'(cur.idx) < TONE_DEPTH)
        tone_mem[TA_W'(cur.idx)] <= cur.val[15:0];
      if (sq_vld && cur.req == REQ_GAIN && 32'(cur.idx) < GAIN_DEPTH)
        gain_mem[GA_W'(cur.idx)] <= cur.val;
      tone_rd_r <= tone_mem[t_addr];
      gain_rd_r <= gain_mem[g_addr];
    end
  end

  logic        m_vld_r, x_vld_r;
  logic [15:0] m_p_r, m_t_r;
  logic        m_en_r;
  logic [15:0] x_i_r, x_p_r, x_t_r;
  logic        x_en_r;
  logic signed [PW-1:0] x_pp_r, x_tp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      x_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= do_pix;
      x_vld_r <= m_vld_r;
      o_vld_r <= x_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_p_r  <= cur.p;
      m_t_r  <= cur.t;
      m_en_r <= en_r;
      x_i_r  <= tone_rd_r;
      x_p_r  <= m_p_r;
      x_t_r  <= m_t_r;
      x_en_r <= m_en_r;
      x_pp_r <= PW'($signed(m_p_r)) * $signed({1'b0, gain_rd_r});
      x_tp_r <= PW'($signed(m_t_r)) * $signed({1'b0, gain_rd_r});
    end
  end

  function automatic logic [15:0] scale_sat(input logic signed [PW-1:0] prod);
    logic signed [PW-1:0] q;
    logic [PW-1:0] mag_v;
    mag_v = prod[PW-1] ? PW'(-prod) : PW'(prod);
    mag_v = mag_v >> GAIN_FRAC_BITS;
    q = prod[PW-1] ? -$signed(mag_v) : $signed(mag_v);
    if (q > SAT_HI) q = SAT_HI;
    if (q < SAT_LO) q = SAT_LO;
    return q[15:0];
  endfunction

  logic [15:0] o_i_r, o_p_r, o_t_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      o_i_r <= x_i_r;
      o_p_r <= x_en_r ? scale_sat(x_pp_r) : x_p_r;
      o_t_r <= x_en_r ? scale_sat(x_tp_r) : x_t_r;
    end
  end

  assign out_valid         = o_vld_r;
  assign out_out_intensity = o_i_r;
  assign out_out_p         = o_p_r;
  assign out_out_t         = o_t_r;

`ifndef SYNTHESIS
  a_ready_follows_out : assert property (@(posedge clk) disable iff (!rst_n)
    (o_vld_r && !out_ready) |-> !in_ready)
    else $error("accepting while output stalled");
  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_out_p) && $stable(out_out_t)))
    else $error("stalled result changed");
  a_mul_only_pixels : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && do_pix) |=> m_vld_r)
    else $error("pixel lost before multiply");
`endif

endmodule

>>> sv/itcla_sqrt.sv
module itcla_sqrt
  import itcla_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [MAG_W-1:0]  in_mag,
  output logic              out_vld,
  output logic [ROOT_W-1:0] out_root
);

  sq_stage_t stg_r [SQRT_STEPS+1];
  sq_stage_t stg_nxt [SQRT_STEPS+1];

  always_comb begin
    logic [33:0] trial;
    logic [31:0] rem2;
    stg_nxt[0].vld  = in_vld;
    stg_nxt[0].rem  = '0;
    stg_nxt[0].rad  = in_mag;
    stg_nxt[0].root = '0;
    for (int k = 1; k <= SQRT_STEPS; k++) begin
      rem2 = {stg_r[k-1].rem[29:0], stg_r[k-1].rad[31:30]};
      trial = {2'b00, rem2} - {16'd0, stg_r[k-1].root, 2'b01};
      stg_nxt[k].vld = stg_r[k-1].vld;
      stg_nxt[k].rad = {stg_r[k-1].rad[29:0], 2'b00};
      if (!trial[33]) begin
        stg_nxt[k].rem  = trial[31:0];
        stg_nxt[k].root = {stg_r[k-1].root[ROOT_W-2:0], 1'b1};
      end else begin
        stg_nxt[k].rem  = rem2;
        stg_nxt[k].root = {stg_r[k-1].root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= SQRT_STEPS; k++) begin
      if (!rst_n) begin
        stg_r[k].vld <= 1'b0;
      end else if (en) begin
        stg_r[k].vld <= stg_nxt[k].vld;
      end
      if (en) begin
        stg_r[k].rem  <= stg_nxt[k].rem;
        stg_r[k].rad  <= stg_nxt[k].rad;
        stg_r[k].root <= stg_nxt[k].root;
      end
    end
  end

  assign out_vld  = stg_r[SQRT_STEPS].vld;
  assign out_root = stg_r[SQRT_STEPS].root;

endmodule

>>> tb/sv/ipt_tone_and_chroma_lut_adjust_core_test.sv
module ipt_tone_and_chroma_lut_adjust_core_test;
  import itcla_pkg::*;

  localparam int TONE_ENTRIES = 65536;
  localparam int GAIN_ENTRIES = 46341;
  localparam int GAIN_SHIFT   = 15;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct {
    req_t              kind;
    logic [15:0]       inten;
    logic signed [15:0] p;
    logic signed [15:0] t;
    logic [15:0]       idx;
    logic [21:0]       val;
  } request_t;

  typedef struct {
    logic [15:0]        inten;
    logic signed [15:0] p;
    logic signed [15:0] t;
  } pixel_out_t;

  class adjust_scoreboard;
    logic [15:0] tone [TONE_ENTRIES];
    logic [21:0] gain [GAIN_ENTRIES];
    bit          tone_set [TONE_ENTRIES];
    bit          gain_set [GAIN_ENTRIES];
    bit          chroma_on;
    pixel_out_t  pending_pixels [$];
    int          mismatches;

    function int unsigned chroma_root(logic signed [15:0] p, logic signed [15:0] t);
      longint unsigned n;
      longint unsigned root;
      longint unsigned b;
      n = longint'(p) * longint'(p) + longint'(t) * longint'(t);
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= root + b) begin
          n -= root + b;
          root = (root >> 1) + b;
        end else begin
          root >>= 1;
        end
        b >>= 2;
      end
      if (root >= 64'(GAIN_ENTRIES)) root = 64'(GAIN_ENTRIES - 1);
      return int'(root);
    endfunction

    function logic signed [15:0] scale_chroma(logic signed [15:0] c, logic [21:0] g);
      longint q;
      q = (longint'(c) * longint'({42'd0, g})) / (longint'(1) << GAIN_SHIFT);
      if (q > 32767) q = 32767;
      if (q < -32767) q = -32767;
      return q[15:0];
    endfunction

    function void note_request(request_t r);
      pixel_out_t e;
      case (r.kind)
        REQ_TONE: begin
          tone[r.idx] = r.val[15:0];
          tone_set[r.idx] = 1'b1;
        end
        REQ_GAIN: begin
          if (r.idx < GAIN_ENTRIES) begin
            gain[r.idx] = r.val;
            gain_set[r.idx] = 1'b1;
          end
        end
        REQ_PIXEL: begin
          e.inten = tone[r.inten];
          e.p = r.p;
          e.t = r.t;
          if (chroma_on) begin
            e.p = scale_chroma(r.p, gain[chroma_root(r.p, r.t)]);
            e.t = scale_chroma(r.t, gain[chroma_root(r.p, r.t)]);
          end
          pending_pixels.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check_result(pixel_out_t got);
      pixel_out_t e;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel: I=%0d P=%0d T=%0d", got.inten, got.p, got.t);
        return;
      end
      e = pending_pixels.pop_front();
      if (got.inten !== e.inten || got.p !== e.p || got.t !== e.t) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch: expected I=%0d P=%0d T=%0d, got I=%0d P=%0d T=%0d",
                   e.inten, e.p, e.t, got.inten, got.p, got.t);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_req_type = REQ_NONE;
  logic [15:0] in_in_intensity = '0;
  logic signed [15:0] in_in_p = '0;
  logic signed [15:0] in_in_t = '0;
  logic [15:0] in_table_index = '0;
  logic [21:0] in_table_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_out_intensity;
  logic signed [15:0] out_out_p;
  logic signed [15:0] out_out_t;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  ipt_tone_and_chroma_lut_adjust_core DUT (.*);

  adjust_scoreboard sb = new();
  int cycles = 0;
  int results_seen = 0;
  bit in_busy_idle = 1'b1;
  bit out_busy_idle = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int draw_gap(bit busy);
    return busy ? $urandom_range(0, 18) : 0;
  endfunction

  task automatic send(request_t r);
    int gap;
    gap = draw_gap(in_busy_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req_type <= r.kind;
    in_in_intensity <= r.inten;
    in_in_p <= r.p;
    in_in_t <= r.t;
    in_table_index <= r.idx;
    in_table_value <= r.val;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
  endtask

  function automatic request_t noise_fields();
    request_t r;
    r.kind = REQ_NONE;
    r.inten = 16'($urandom());
    r.p = 16'($urandom());
    r.t = 16'($urandom());
    r.idx = 16'($urandom());
    r.val = 22'($urandom());
    return r;
  endfunction

  task automatic table_write(req_t kind, logic [15:0] idx, logic [21:0] val);
    request_t r;
    r = noise_fields();
    r.kind = kind;
    r.idx = idx;
    r.val = val;
    send(r);
  endtask

  // fill any table entry the pixel would read before sending it
  task automatic pixel(logic [15:0] inten, logic signed [15:0] p, logic signed [15:0] t);
    request_t r;
    int c;
    if (!sb.tone_set[inten]) table_write(REQ_TONE, inten, 22'($urandom()));
    c = sb.chroma_root(p, t);
    if (sb.chroma_on && !sb.gain_set[c]) table_write(REQ_GAIN, 16'(c), 22'($urandom()));
    r = noise_fields();
    r.kind = REQ_PIXEL;
    r.inten = inten;
    r.p = p;
    r.t = t;
    send(r);
  endtask

  task automatic set_chroma(logic [31:0] v);
    in_valid <= 1'b0;
    wait (sb.pending_pixels.size() == 0);
    repeat (40) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_ENABLE[1:0];
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.chroma_on = v[0];
  endtask

  task automatic random_phase(int count);
    int k;
    int pick;
    logic signed [15:0] p;
    logic signed [15:0] t;
    for (k = 0; k < count; k++) begin
      if (k % 100 == 0) in_busy_idle = $urandom_range(0, 2) != 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if ($urandom_range(0, 1)) begin
          p = 16'($urandom());
          t = 16'($urandom());
        end else begin
          p = $signed(16'($urandom_range(0, 80))) - 16'sd40;
          t = $signed(16'($urandom_range(0, 80))) - 16'sd40;
        end
        pixel($urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 63)), p, t);
      end else if (pick < 75) begin
        table_write(REQ_TONE, 16'($urandom()), 22'($urandom()));
      end else if (pick < 92) begin
        table_write(REQ_GAIN, $urandom_range(0, 1) ? 16'($urandom()) :
                    16'($urandom_range(0, 60)), 22'($urandom()));
      end else begin
        send(noise_fields());
      end
    end
  endtask

  // result side: random stalls, one long hold-off once the stream is running
  initial begin
    int stall;
    bit held;
    pixel_out_t got;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (results_seen % 150 == 0) out_busy_idle = $urandom_range(0, 2) != 0;
      stall = draw_gap(out_busy_idle);
      if (!held && results_seen >= 300) begin
        stall = 500;
        held = 1'b1;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.inten = out_out_intensity;
      got.p = out_out_p;
      got.t = out_out_t;
      sb.check_result(got);
      results_seen++;
    end
  end

  initial begin
    int k;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pass-through, tone extremes, most negative chroma
    in_busy_idle = 1'b0;
    pixel(16'd0, 16'sh8000, 16'sh7FFF);
    pixel(16'hFFFF, 16'sh7FFF, 16'sh8000);
    table_write(REQ_TONE, 16'hFFFF, 22'h3FFFFF);
    pixel(16'hFFFF, 16'sd0, -16'sd1);
    send(noise_fields());

    set_chroma(32'd1);
    table_write(REQ_GAIN, 16'd1, 22'd32768);
    pixel(16'd0, 16'sh8000, 16'sd0);
    table_write(REQ_GAIN, 16'd46340, 22'h3FFFFF);
    pixel(16'd5, 16'sh8000, 16'sh8000);
    pixel(16'd6, 16'sh7FFF, 16'sh7FFF);
    table_write(REQ_GAIN, 16'd0, 22'd0);
    pixel(16'd7, 16'sd0, 16'sd0);
    table_write(REQ_GAIN, 16'd46341, 22'd1);
    table_write(REQ_GAIN, 16'hFFFF, 22'd1);
    pixel(16'd8, 16'sh8000, 16'sh8000);
    table_write(REQ_GAIN, 16'd3, 22'd16384);
    pixel(16'd9, -16'sd3, 16'sd0);
    pixel(16'd9, 16'sd3, 16'sd0);

    set_chroma(32'd0);
    random_phase(200);
    set_chroma(32'd1);
    random_phase(300);
    set_chroma(32'hFFFF_FFFE);
    random_phase(100);
    set_chroma(32'hFFFF_FFFF);
    random_phase(220);
    in_valid <= 1'b0;

    wait (sb.pending_pixels.size() == 0);
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
